### sv/ihbf_pkg.sv
// ----------------------------------------------------------------------------
// ihbf_pkg
// Shared constants and types for the Intel HEX to boot frame converter.
// ----------------------------------------------------------------------------
package ihbf_pkg;

  localparam int MaxBytes = 5;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_END   = 8'h03;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  typedef logic [$clog2(MaxBytes+1)-1:0] count_t;

  // Bytes caused by one input word, element 0 goes out first.
  typedef struct packed {
    count_t                     count;
    logic [MaxBytes-1:0][7:0]   bytes;
    logic                       finished;
  } frame_t;

endpackage

### sv/intel_hex_to_boot_frames.sv
// The first frame byte of an input word is offered in the cycle after the word is taken.
// Throughput: one word per cycle while each word yields at most one byte and out_ready is
// high; a word that yields more bytes holds off the next word until its last byte is taken.
// Reset: synchronous rst clears the parser state and drops any queued frame bytes.
// ----------------------------------------------------------------------------
// intel_hex_to_boot_frames
// Converts an Intel HEX character stream into serial bootloader frames.
// ----------------------------------------------------------------------------
module intel_hex_to_boot_frames (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  ihbf_pkg::frame_t                     frame;
  ihbf_pkg::count_t                     remaining;
  logic [ihbf_pkg::MaxBytes-1:0][7:0]   sbuf;
  logic                                 in_acc;
  logic                                 out_acc;

  assign out_valid   = remaining != '0;
  assign out_byte    = sbuf[0];
  assign last_of_run = remaining == ihbf_pkg::count_t'(1);
  assign in_ready    = (remaining == '0) || (last_of_run && out_ready);
  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;

  ihbf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_acc),
    .op      (op),
    .in_char (in_char),
    .frame   (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (in_acc) begin
      remaining <= frame.count;
    end else if (out_acc) begin
      remaining <= remaining - ihbf_pkg::count_t'(1);
    end
  end

  // load a new burst, or advance to the next byte of the current one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sbuf <= frame.bytes;
    end else if (out_acc) begin
      sbuf <= {8'd0, sbuf[ihbf_pkg::MaxBytes-1:1]};
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= ihbf_pkg::count_t'(ihbf_pkg::MaxBytes)) else $error("queue overfilled");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> remaining == '0 || (remaining == ihbf_pkg::count_t'(1) && out_acc))
    else $error("burst overwritten before drained");
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_acc && !last_of_run |=> out_valid) else $error("burst broken");
  a_fin_quiet: assert property (@(posedge clk) disable iff (rst)
    in_acc && frame.finished |=> !out_valid) else $error("word after finish");

endmodule

### sv/ihbf_parser.sv
// ----------------------------------------------------------------------------
// ihbf_parser
// Record parser state and the burst of frame bytes for each input word.
// ----------------------------------------------------------------------------
module ihbf_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               op,
  input  logic [7:0]         in_char,
  output ihbf_pkg::frame_t   frame
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CHECK  = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  logic [2:0]  line_phase,     line_phase_next;
  logic [9:0]  digit_position, digit_position_next;
  logic [3:0]  high_nibble,    high_nibble_next;
  logic [7:0]  record_length,  record_length_next;
  logic [15:0] record_offset,  record_offset_next;
  logic [7:0]  record_kind,    record_kind_next;
  logic [7:0]  data_left,      data_left_next;
  logic [31:0] checksum_total, checksum_total_next;
  logic        finished,       finished_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  pair;
  logic [8:0]  idx;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_char >= 8'h30 && in_char <= 8'h39) begin
      hex_val = 4'(in_char - 8'h30);
    end else if (in_char >= 8'h41 && in_char <= 8'h46) begin
      hex_val = 4'(in_char - 8'h37);
    end else if (in_char >= 8'h61 && in_char <= 8'h66) begin
      hex_val = 4'(in_char - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign pair = {high_nibble, hex_val};
  assign idx  = digit_position[9:1];

  always_comb begin
    line_phase_next     = line_phase;
    digit_position_next = digit_position;
    high_nibble_next    = high_nibble;
    record_length_next  = record_length;
    record_offset_next  = record_offset;
    record_kind_next    = record_kind;
    data_left_next      = data_left;
    checksum_total_next = checksum_total;
    finished_next       = finished;
    frame.count         = '0;
    frame.bytes         = '0;

    if (!finished) begin
      if (op) begin
        frame.count    = ihbf_pkg::count_t'(5);
        frame.bytes[0] = ihbf_pkg::FRAME_END;
        frame.bytes[1] = checksum_total[31:24];
        frame.bytes[2] = checksum_total[23:16];
        frame.bytes[3] = checksum_total[15:8];
        frame.bytes[4] = checksum_total[7:0];
        finished_next   = 1'b1;
        line_phase_next = PH_SKIP;
      end else if (line_phase == PH_START) begin
        if (in_char == ihbf_pkg::CHAR_COLON) begin
          line_phase_next     = PH_HEADER;
          digit_position_next = '0;
        end else if (in_char != ihbf_pkg::CHAR_NEWLINE) begin
          line_phase_next = PH_SKIP;
        end
      end else if (line_phase == PH_HEADER || line_phase == PH_DATA ||
                   line_phase == PH_CHECK) begin
        if (!hex_ok) begin
          line_phase_next = (in_char == ihbf_pkg::CHAR_NEWLINE) ? PH_START : PH_SKIP;
        end else if (!digit_position[0]) begin
          high_nibble_next    = hex_val;
          digit_position_next = digit_position + 10'd1;
        end else begin
          digit_position_next = digit_position + 10'd1;
          if (line_phase == PH_HEADER) begin
            if (idx == 9'd0) begin
              record_length_next = pair;
              data_left_next     = pair;
            end else if (idx == 9'd1) begin
              record_offset_next = {pair, record_offset[7:0]};
            end else if (idx == 9'd2) begin
              record_offset_next = {record_offset[15:8], pair};
            end else begin
              record_kind_next = pair;
              if (pair == ihbf_pkg::REC_DATA) begin
                frame.count    = ihbf_pkg::count_t'(4);
                frame.bytes[0] = ihbf_pkg::FRAME_START;
                frame.bytes[1] = record_offset[15:8];
                frame.bytes[2] = record_offset[7:0];
                frame.bytes[3] = record_length;
                line_phase_next = (data_left != 8'd0) ? PH_DATA : PH_CHECK;
              end else if (pair == ihbf_pkg::REC_EOF) begin
                frame.count    = ihbf_pkg::count_t'(5);
                frame.bytes[0] = ihbf_pkg::FRAME_END;
                frame.bytes[1] = checksum_total[31:24];
                frame.bytes[2] = checksum_total[23:16];
                frame.bytes[3] = checksum_total[15:8];
                frame.bytes[4] = checksum_total[7:0];
                finished_next   = 1'b1;
                line_phase_next = PH_SKIP;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end
          end else if (line_phase == PH_DATA) begin
            frame.count    = ihbf_pkg::count_t'(1);
            frame.bytes[0] = pair;
            data_left_next = data_left - 8'd1;
            if (data_left == 8'd1) line_phase_next = PH_CHECK;
          end else begin
            frame.count         = ihbf_pkg::count_t'(1);
            frame.bytes[0]      = pair;
            checksum_total_next = checksum_total + {24'd0, pair};
            line_phase_next     = PH_SKIP;
          end
        end
      end else begin
        // skip to end of line, unused codes included
        if (in_char == ihbf_pkg::CHAR_NEWLINE) line_phase_next = PH_START;
      end
    end
    frame.finished = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase     <= PH_START;
      digit_position <= '0;
      high_nibble    <= '0;
      record_length  <= '0;
      record_offset  <= '0;
      record_kind    <= '0;
      data_left      <= '0;
      checksum_total <= '0;
      finished       <= 1'b0;
    end else if (accept) begin
      line_phase     <= line_phase_next;
      digit_position <= digit_position_next;
      high_nibble    <= high_nibble_next;
      record_length  <= record_length_next;
      record_offset  <= record_offset_next;
      record_kind    <= record_kind_next;
      data_left      <= data_left_next;
      checksum_total <= checksum_total_next;
      finished       <= finished_next;
    end
  end

  // finished is sticky
  a_fin_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished) else $error("finished flag dropped");
  // data phase never entered with nothing left
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    line_phase == PH_DATA |-> data_left != 8'd0) else $error("data phase with zero left");
  // nothing is produced once finished
  a_fin_quiet: assert property (@(posedge clk) disable iff (rst)
    finished |-> frame.count == '0) else $error("output after finish");

endmodule

### tb/ihbf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihbf_checker
// Watches both channels of the HEX to boot frame converter, predicts the
// frame bytes of every taken character word and compares them in order.
// ----------------------------------------------------------------------------
module ihbf_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       op,
  input  logic [7:0] in_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last_of_run,
  output int         fail_count,
  output int         expected_left
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_HEADER = 3'd1,
    PH_DATA   = 3'd2,
    PH_CHECK  = 3'd3,
    PH_SKIP   = 3'd4
  } line_phase_e;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  line_phase_e phase;
  logic [9:0]  digits_seen;
  logic [3:0]  hi_nib;
  logic [7:0]  rec_len;
  logic [15:0] rec_offs;
  logic [7:0]  rec_kind;
  logic [7:0]  bytes_left;
  logic [31:0] check_sum;
  logic        done;

  frame_byte_t frame_bytes_due[$];
  logic [7:0]  word_bytes[$];

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic emit(input logic [7:0] b);
    word_bytes.push_back(b);
  endtask

  task automatic emit_end_frame();
    emit(ihbf_pkg::FRAME_END);
    emit(check_sum[31:24]);
    emit(check_sum[23:16]);
    emit(check_sum[15:8]);
    emit(check_sum[7:0]);
    done = 1'b1;
    phase = PH_SKIP;
  endtask

  task automatic predict_frame_bytes(input logic eof, input logic [7:0] c);
    int         nib;
    logic [7:0] b;
    logic [8:0] pair_idx;
    word_bytes.delete();
    if (!done) begin
      if (eof) begin
        emit_end_frame();
      end else begin
        case (phase)
          PH_START: begin
            if (c == ihbf_pkg::CHAR_COLON) begin
              phase = PH_HEADER;
              digits_seen = '0;
            end else if (c != ihbf_pkg::CHAR_NEWLINE) begin
              phase = PH_SKIP;
            end
          end
          PH_HEADER, PH_DATA, PH_CHECK: begin
            nib = hex_nibble(c);
            if (nib < 0) begin
              // newline restarts the line, anything else drops the record
              phase = (c == ihbf_pkg::CHAR_NEWLINE) ? PH_START : PH_SKIP;
            end else if (!digits_seen[0]) begin
              hi_nib = nib[3:0];
              digits_seen++;
            end else begin
              b = {hi_nib, nib[3:0]};
              pair_idx = digits_seen[9:1];
              digits_seen++;
              case (phase)
                PH_HEADER: begin
                  case (pair_idx)
                    9'd0: begin
                      rec_len = b;
                      bytes_left = b;
                    end
                    9'd1: rec_offs[15:8] = b;
                    9'd2: rec_offs[7:0] = b;
                    default: begin
                      rec_kind = b;
                      if (b == ihbf_pkg::REC_DATA) begin
                        emit(ihbf_pkg::FRAME_START);
                        emit(rec_offs[15:8]);
                        emit(rec_offs[7:0]);
                        emit(rec_len);
                        phase = (bytes_left != 0) ? PH_DATA : PH_CHECK;
                      end else if (b == ihbf_pkg::REC_EOF) begin
                        emit_end_frame();
                      end else begin
                        phase = PH_SKIP;
                      end
                    end
                  endcase
                end
                PH_DATA: begin
                  emit(b);
                  bytes_left--;
                  if (bytes_left == 0) phase = PH_CHECK;
                end
                default: begin
                  emit(b);
                  check_sum += {24'd0, b};
                  phase = PH_SKIP;
                end
              endcase
            end
          end
          default: begin
            if (c == ihbf_pkg::CHAR_NEWLINE) phase = PH_START;
          end
        endcase
      end
    end
    foreach (word_bytes[i])
      frame_bytes_due.push_back('{value: word_bytes[i], last: (i == word_bytes.size() - 1)});
  endtask

  always @(posedge clk) begin
    frame_byte_t due;
    if (rst) begin
      phase = PH_START;
      digits_seen = '0;
      hi_nib = '0;
      rec_len = '0;
      rec_offs = '0;
      rec_kind = '0;
      bytes_left = '0;
      check_sum = '0;
      done = 1'b0;
      frame_bytes_due.delete();
    end else begin
      if (in_valid && in_ready) predict_frame_bytes(op, in_char);
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", out_byte));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_byte !== due.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, due.value));
          if (last_of_run !== due.last)
            report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                      last_of_run, due.last, due.value));
        end
      end
    end
    expected_left <= frame_bytes_due.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the HEX to boot frame converter with directed and random HEX text
// under bursty input and stalling output, then reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 20;
  localparam int RandomWords = 520;

  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MASK,
    READY_SPARSE
  } ready_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  int fail_count;
  int expected_left;
  int words_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  ready_mode_e ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  logic [7:0]  stall_mask = 8'hFF;

  intel_hex_to_boot_frames DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .in_char    (in_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  ihbf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: switch at random between stall patterns.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 80);
      stall_mask = 8'($urandom_range(1, 255));
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_MASK: begin
        out_ready <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_word(input logic eof, input logic [7:0] c);
    in_valid <= 1'b1;
    op <= eof;
    in_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    if (n < 10) return DIGIT_0 + n;
    return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + n - 8'd10;
  endfunction

  function automatic logic [7:0] nonhex_char();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h00, 8'h09));
      1:       return 8'($urandom_range(8'h0B, 8'h2F));
      2:       return 8'($urandom_range(8'h3A, 8'h40));
      3:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] c;
    c = 8'($urandom_range(0, 254));
    return (c >= ihbf_pkg::CHAR_NEWLINE) ? c + 8'd1 : c;
  endfunction

  // Send one record line; cut >= 0 breaks it off before that hex digit.
  task automatic send_record(input int len, input logic [15:0] offs, input logic [7:0] kind,
                             input int cut, input bit trail);
    logic [7:0] rec[$];
    logic [3:0] nib;
    rec.push_back(len[7:0]);
    rec.push_back(offs[15:8]);
    rec.push_back(offs[7:0]);
    rec.push_back(kind);
    repeat (len + 1) rec.push_back(8'($urandom_range(0, 255)));
    send_word(1'b0, ihbf_pkg::CHAR_COLON);
    for (int d = 0; d < 2 * rec.size(); d++) begin
      if (d == cut) begin
        if ($urandom_range(0, 1)) begin
          send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
        end else begin
          send_word(1'b0, nonhex_char());
          repeat ($urandom_range(0, 3)) send_word(1'b0, any_but_newline());
          send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
        end
        return;
      end
      nib = d[0] ? rec[d / 2][3:0] : rec[d / 2][7:4];
      send_word(1'b0, hex_ascii(nib));
    end
    if (trail) repeat ($urandom_range(1, 4)) send_word(1'b0, any_but_newline());
    send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
  endfunction

  initial begin
    string      directed;
    bit         drained_once;
    int         pick;
    int         len;
    logic [7:0] c;
    directed = "\n:00ffFF00FFz\n:0G\n:05\n#\n";
    drained_once = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty line, zero-length record at the top offset with trailing text,
    // bad digit, newline inside a record, line without a colon
    for (int i = 0; i < directed.len(); i++) send_word(1'b0, directed[i]);

    send_record(60, 16'($urandom_range(0, 65535)), ihbf_pkg::REC_DATA, -1, 1'b0);

    while (words_sent < RandomWords) begin
      if (!drained_once && words_sent > RandomWords / 2) begin
        wait_for_drain();
        drained_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      len = pick_len();
      if (pick < 55) begin
        send_record(len, 16'($urandom_range(0, 65535)), ihbf_pkg::REC_DATA, -1,
                    $urandom_range(0, 3) == 0);
      end else if (pick < 65) begin
        send_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(2, 255)), -1, 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        send_record(len, 16'($urandom_range(0, 65535)), ihbf_pkg::REC_DATA,
                    $urandom_range(0, 2 * (len + 5) - 1), 1'b0);
      end else if (pick < 88) begin
        do c = any_but_newline(); while (c == ihbf_pkg::CHAR_COLON);
        send_word(1'b0, c);
        repeat ($urandom_range(0, 6)) send_word(1'b0, any_but_newline());
        send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
      end else if (pick < 93) begin
        send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
      end else begin
        repeat ($urandom_range(1, 8)) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b0, ihbf_pkg::CHAR_NEWLINE);
      end
    end

    // close with an end record or the end of file, then check nothing follows
    if ($urandom_range(0, 1))
      send_record(0, 16'($urandom_range(0, 65535)), ihbf_pkg::REC_EOF, -1, 1'b0);
    else
      send_word(1'b1, 8'($urandom_range(0, 255)));
    send_word(1'b1, 8'($urandom_range(0, 255)));
    send_record(2, 16'($urandom_range(0, 65535)), ihbf_pkg::REC_DATA, -1, 1'b0);
    repeat (6) send_word(1'b0, 8'($urandom_range(0, 255)));

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ihbf_pkg.sv
sv/ihbf_parser.sv
sv/intel_hex_to_boot_frames.sv
tb/ihbf_checker.sv
tb/tb_top.sv
